// File: hw/rtl/bpa_pkg.sv
`timescale 1ns / 1ps

package bpa_pkg;

	// Page numbers, page counts and the search cursor share this width.
	localparam int PAGE_W = 17;
	localparam int IDX_W = 16;
	localparam int CMD_W = 2;
	localparam int STATUS_W = 2;
	localparam int OUT_DATA_W = 40;

	localparam int MAX_PAGES_DEF = 65536;
	localparam int WORD_BITS_DEF = 64;

	localparam logic [PAGE_W-1:0] TOTAL_PAGES_RESET = 17'd65536;
	localparam logic [PAGE_W-1:0] COUNT_MAX = 17'h1FFFF;

	localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RESERVE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_FREE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ALREADY = 2'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

	typedef struct packed {
		logic              start;
		logic [PAGE_W-1:0] dividend;
		logic [PAGE_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [PAGE_W-1:0] quotient;
		logic [PAGE_W-1:0] remainder;
	} div_rsp_t;

endpackage

// File: hw/rtl/bpa_divider.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle through a single subtractor.
module bpa_divider import bpa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CntW = $clog2(PAGE_W + 1);

	logic [PAGE_W-1:0] rem_q;
	logic [PAGE_W-1:0] quo_q;
	logic [PAGE_W-1:0] dvs_q;
	logic [CntW-1:0]   cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [PAGE_W:0]   trial;
	logic [PAGE_W:0]   diff;

	assign trial = {rem_q, quo_q[PAGE_W-1]};
	assign diff = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CntW'(1);
				if (cnt_q == CntW'(PAGE_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			// The borrow bit tells whether the trial remainder reached the divisor.
			if (!diff[PAGE_W]) begin
				rem_q <= diff[PAGE_W-1:0];
				quo_q <= {quo_q[PAGE_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[PAGE_W-1:0];
				quo_q <= {quo_q[PAGE_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;
	assign rsp.remainder = rem_q;

endmodule

// File: hw/rtl/bitmap_page_allocator_top.sv
`timescale 1ns / 1ps
// Allocate reduces the cursor with the divider, then scans 1 to WordCount + 1
// bitmap words; free and reserve read one word and write it back if the bit changes; a
// command with an out-of-range index, no pages or no operation goes straight to the result.
// Throughput: one command at a time; the next word is taken once the result is registered.
// Reset: arst_n clears control state at once, then a clearing pass writes every bitmap word
// to all ones before the first word is taken.
module bitmap_page_allocator_top import bpa_pkg::*; #(
	parameter int MAX_PAGES = MAX_PAGES_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Command channel.
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IDX_W-1:0]      s_tdata,   // [15:0] page_index
	input  logic [CMD_W-1:0]      s_tuser,   // [1:0] cmd
	// Result channel.
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [15:0] granted_page, [32:16] free_pages, rest 0
	output logic [STATUS_W-1:0]   m_tuser,   // [1:0] status
	// Configuration write channel for total_pages.
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [PAGE_W-1:0]     cfg_data
);

	// The bitmap is held as WordCount words of WORD_BITS bits, one bit per page, 1 = used.
	localparam int WordCount = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int AW = (WordCount > 1) ? $clog2(WordCount) : 1;
	localparam int BIW = $clog2(WORD_BITS);
	// The effective page count never exceeds what the cursor width can express.
	localparam int MaxCap = (MAX_PAGES > 131071) ? 131071 : MAX_PAGES;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV_MOD,
		S_SCAN,
		S_RMW_RD,
		S_RMW_CHK,
		S_RESULT
	} state_t;

	state_t               state_q;
	logic [AW-1:0]        clr_addr_q;
	logic [PAGE_W-1:0]    total_pages_q;
	logic [PAGE_W-1:0]    free_total_q;
	logic [PAGE_W-1:0]    next_search_q;
	logic [CMD_W-1:0]     cmd_q;
	logic [AW-1:0]        word_q;
	logic [BIW-1:0]       bit_q;
	div_req_t             div_req_q;
	div_rsp_t             div_rsp;

	// Scan issue side: the word whose read goes out this cycle.
	logic [AW-1:0]        iss_addr_q;
	logic [PAGE_W-1:0]    iss_base_q;
	logic                 iss_active_q;
	logic                 iss_first_q;
	logic                 iss_wrap_q;
	// Scan check side: the word whose read data is in rdata_q.
	logic                 chk_valid_s1;
	logic [AW-1:0]        chk_addr_s1;
	logic [PAGE_W-1:0]    chk_base_s1;
	logic                 chk_first_s1;
	logic                 chk_final_s1;

	logic [STATUS_W-1:0]  res_status_q;
	logic [IDX_W-1:0]     res_granted_q;
	logic                 m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic [STATUS_W-1:0]  m_tuser_q;

	logic [WORD_BITS-1:0] mem [WordCount];
	logic [WORD_BITS-1:0] rdata_q;
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic [AW-1:0]        mem_raddr;

	logic [PAGE_W-1:0]    n_pages;
	logic [PAGE_W:0]      iss_next_base;
	logic                 iss_past_end;
	logic                 iss_final;
	logic [PAGE_W-1:0]    lim;
	logic [WORD_BITS-1:0] vmask;
	logic [WORD_BITS-1:0] avail;
	logic [WORD_BITS-1:0] low;
	logic [BIW-1:0]       low_idx;
	logic                 found;
	logic [PAGE_W-1:0]    found_page;
	logic                 want_used;
	logic                 bit_sel;
	logic [WORD_BITS-1:0] bit_onehot;
	logic [PAGE_W-1:0]    count_down;
	logic [PAGE_W-1:0]    count_up;

	bpa_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req_q),
		.rsp    (div_rsp)
	);

	assign n_pages = (total_pages_q > PAGE_W'(MaxCap)) ? PAGE_W'(MaxCap) : total_pages_q;

	// The next word's base page decides whether the scan wraps to word zero.
	assign iss_next_base = {1'b0, iss_base_q} + (PAGE_W + 1)'(WORD_BITS);
	assign iss_past_end = iss_next_base >= {1'b0, n_pages};
	// After the wrap the scan ends by revisiting the start word below the start bit.
	assign iss_final = iss_wrap_q && (iss_addr_q == word_q);

	// Every issued word starts below the page count, so this difference is positive.
	assign lim = n_pages - chk_base_s1;

	always_comb begin
		for (int j = 0; j < WORD_BITS; j++) begin
			vmask[j] = (PAGE_W'(j) < lim)
				&& (!chk_first_s1 || (BIW'(j) >= bit_q))
				&& (!chk_final_s1 || (BIW'(j) < bit_q));
		end
	end

	assign avail = ~rdata_q & vmask;
	assign low = avail & (~avail + WORD_BITS'(1));
	assign found = |avail;

	always_comb begin
		low_idx = '0;
		for (int j = 0; j < WORD_BITS; j++) begin
			if (low[j]) begin
				low_idx = low_idx | BIW'(j);
			end
		end
	end

	assign found_page = chk_base_s1 + PAGE_W'(low_idx);

	assign want_used = (cmd_q == CMD_RESERVE);
	assign bit_sel = rdata_q[bit_q];
	assign bit_onehot = WORD_BITS'(1) << bit_q;

	// The free count saturates at both ends.
	assign count_down = (free_total_q != '0) ? free_total_q - PAGE_W'(1) : free_total_q;
	assign count_up = (free_total_q != COUNT_MAX) ? free_total_q + PAGE_W'(1) : free_total_q;

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = word_q;
		mem_wdata = rdata_q;
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				mem_waddr = clr_addr_q;
				mem_wdata = '1;
			end
			S_SCAN: begin
				mem_we = chk_valid_s1 && found;
				mem_waddr = chk_addr_s1;
				mem_wdata = rdata_q | low;
			end
			S_RMW_CHK: begin
				mem_we = (bit_sel != want_used);
				mem_waddr = word_q;
				mem_wdata = want_used ? (rdata_q | bit_onehot) : (rdata_q & ~bit_onehot);
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	assign mem_raddr = (state_q == S_SCAN) ? iss_addr_q : word_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_addr_q <= '0;
			total_pages_q <= TOTAL_PAGES_RESET;
			free_total_q <= '0;
			next_search_q <= '0;
			cmd_q <= CMD_ALLOC;
			word_q <= '0;
			bit_q <= '0;
			div_req_q <= '0;
			iss_addr_q <= '0;
			iss_base_q <= '0;
			iss_active_q <= 1'b0;
			iss_first_q <= 1'b0;
			iss_wrap_q <= 1'b0;
			chk_valid_s1 <= 1'b0;
			chk_addr_s1 <= '0;
			chk_base_s1 <= '0;
			chk_first_s1 <= 1'b0;
			chk_final_s1 <= 1'b0;
			res_status_q <= ST_DONE;
			res_granted_q <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q <= '0;
			m_tuser_q <= ST_DONE;
		end else begin
			// Only an allocate with pages to manage needs the cursor reduced by the divider.
			div_req_q.start <= (state_q == S_IDLE) && s_tvalid && (s_tuser == CMD_ALLOC)
				&& (n_pages != '0);
			if (cfg_valid) begin
				total_pages_q <= cfg_data;
			end
			// The result register loads in S_RESULT and empties when its word is taken.
			if ((state_q == S_RESULT) && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == AW'(WordCount - 1)) begin
						state_q <= S_IDLE;
					end
				end

				S_IDLE: begin
					if (s_tvalid) begin
						cmd_q <= s_tuser;
						res_granted_q <= '0;
						case (s_tuser)
							CMD_ALLOC: begin
								if (n_pages == '0) begin
									res_status_q <= ST_NO_FREE;
									state_q <= S_RESULT;
								end else begin
									// Reduce the cursor modulo the page count first.
									div_req_q.dividend <= next_search_q;
									div_req_q.divisor <= n_pages;
									state_q <= S_DIV_MOD;
								end
							end
							CMD_FREE, CMD_RESERVE: begin
								if ({1'b0, s_tdata} >= n_pages) begin
									res_status_q <= ST_RANGE;
									state_q <= S_RESULT;
								end else begin
									// WORD_BITS is a power of two, so a page splits into
									// its word and bit by a shift and a mask.
									word_q <= AW'(s_tdata >> BIW);
									bit_q <= s_tdata[BIW-1:0];
									state_q <= S_RMW_RD;
								end
							end
							default: begin
								res_status_q <= ST_DONE;
								state_q <= S_RESULT;
							end
						endcase
					end
				end

				S_DIV_MOD: begin
					if (div_rsp.done) begin
						word_q <= AW'(div_rsp.remainder >> BIW);
						bit_q <= div_rsp.remainder[BIW-1:0];
						iss_addr_q <= AW'(div_rsp.remainder >> BIW);
						iss_base_q <= {div_rsp.remainder[PAGE_W-1:BIW], BIW'(0)};
						iss_active_q <= 1'b1;
						iss_first_q <= 1'b1;
						iss_wrap_q <= 1'b0;
						chk_valid_s1 <= 1'b0;
						state_q <= S_SCAN;
					end
				end

				S_SCAN: begin
					if (chk_valid_s1 && (found || chk_final_s1)) begin
						// The checked word ends the scan, with or without a free page.
						if (found) begin
							free_total_q <= count_down;
							next_search_q <= found_page + PAGE_W'(1);
							res_granted_q <= found_page[IDX_W-1:0];
							res_status_q <= ST_DONE;
						end else begin
							res_status_q <= ST_NO_FREE;
						end
						iss_active_q <= 1'b0;
						chk_valid_s1 <= 1'b0;
						state_q <= S_RESULT;
					end else if (iss_active_q) begin
						// One word read goes out per cycle while the previous one is checked.
						chk_valid_s1 <= 1'b1;
						chk_addr_s1 <= iss_addr_q;
						chk_base_s1 <= iss_base_q;
						chk_first_s1 <= iss_first_q;
						chk_final_s1 <= iss_final;
						iss_first_q <= 1'b0;
						if (iss_final) begin
							iss_active_q <= 1'b0;
						end else if (iss_past_end) begin
							iss_addr_q <= '0;
							iss_base_q <= '0;
							iss_wrap_q <= 1'b1;
						end else begin
							iss_addr_q <= iss_addr_q + AW'(1);
							iss_base_q <= iss_next_base[PAGE_W-1:0];
						end
					end else begin
						chk_valid_s1 <= 1'b0;
					end
				end

				S_RMW_RD: begin
					state_q <= S_RMW_CHK;
				end

				S_RMW_CHK: begin
					if (bit_sel == want_used) begin
						res_status_q <= ST_ALREADY;
					end else begin
						res_status_q <= ST_DONE;
						free_total_q <= want_used ? count_down : count_up;
					end
					state_q <= S_RESULT;
				end

				S_RESULT: begin
					// The result register frees up when its word is taken.
					if (!m_tvalid_q || m_tready) begin
						m_tuser_q <= res_status_q;
						m_tdata_q <= {(OUT_DATA_W - PAGE_W - IDX_W)'(0), free_total_q,
							res_granted_q};
						state_q <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

endmodule

// File: hw/rtl/bpa_checker.sv
`timescale 1ns / 1ps

module bpa_checker import bpa_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic [STATUS_W-1:0]   m_tuser
);

	// A stalled result word holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// Only a successful command carries a granted page.
	a_grant: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ST_DONE) |-> (m_tdata[IDX_W-1:0] == '0))
		else $error("granted page set on a failed command");

	// A command is worked on alone: the block stops taking words right after one.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second command taken while busy");

	// A new result word never appears straight after the block was waiting for a command.
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result word without a command in progress");

endmodule

bind bitmap_page_allocator_top bpa_checker u_bpa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tuser   (m_tuser)
);

// File: verif/bpa_result_checker.sv
`timescale 1ns / 1ps

module bpa_result_checker import bpa_pkg::*; #(
	parameter int MAX_PAGES = MAX_PAGES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IDX_W-1:0]      s_tdata,   // [15:0] page_index
	input  logic [CMD_W-1:0]      s_tuser,   // [1:0] cmd
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,   // [15:0] granted_page, [32:16] free_pages
	input  logic [STATUS_W-1:0]   m_tuser,   // [1:0] status
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [PAGE_W-1:0]     cfg_data,
	output int                    mismatches,
	output int                    results_pending
);

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [IDX_W-1:0]    granted;
		logic [PAGE_W-1:0]   free_pages;
	} page_result_t;

	// Shadow of the allocator: one bit per page, set when the page is in use.
	bit                page_taken [MAX_PAGES];
	logic [PAGE_W-1:0] shadow_free;
	logic [PAGE_W-1:0] search_from;
	logic [PAGE_W-1:0] page_limit;
	page_result_t      results_due [$];

	task automatic clear_model();
		for (int p = 0; p < MAX_PAGES; p++)
			page_taken[p] = 1'b1;
		shadow_free = '0;
		search_from = '0;
		page_limit = TOTAL_PAGES_RESET;
	endtask

	// Applies one command to the shadow state and returns the result it must produce.
	task automatic apply_page_command(input logic [CMD_W-1:0] cmd,
			input logic [IDX_W-1:0] idx, output page_result_t res);
		int  n;
		int  start;
		int  p;
		bit  found;
		n = (page_limit > MAX_PAGES) ? MAX_PAGES : int'(page_limit);
		res = '0;
		found = 1'b0;
		if (cmd == CMD_ALLOC) begin
			res.status = ST_NO_FREE;
			if (n > 0) begin
				start = int'(search_from) % n;
				for (int i = 0; i < n && !found; i++) begin
					p = start + i;
					if (p >= n)
						p -= n;
					if (!page_taken[p]) begin
						found = 1'b1;
						page_taken[p] = 1'b1;
						if (shadow_free != 0)
							shadow_free--;
						search_from = PAGE_W'(p + 1);
						res.granted = IDX_W'(p);
						res.status = ST_DONE;
					end
				end
			end
		end else if (cmd == CMD_FREE || cmd == CMD_RESERVE) begin
			if (int'(idx) >= n) begin
				res.status = ST_RANGE;
			end else if (page_taken[idx] == (cmd == CMD_RESERVE)) begin
				res.status = ST_ALREADY;
			end else begin
				page_taken[idx] = (cmd == CMD_RESERVE);
				if (cmd == CMD_RESERVE) begin
					if (shadow_free != 0)
						shadow_free--;
				end else if (shadow_free != COUNT_MAX) begin
					shadow_free++;
				end
			end
		end
		res.free_pages = shadow_free;
	endtask

	task automatic flag_mismatch(input string what, input page_result_t want,
			input page_result_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: expected status %0d page %0d free %0d,",
				$time, what, want.status, want.granted, want.free_pages,
				" got status %0d page %0d free %0d",
				got.status, got.granted, got.free_pages);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		page_result_t want;
		page_result_t got;
		if (!arst_n) begin
			clear_model();
			results_due.delete();
			mismatches = 0;
		end else begin
			// Order matters only for the shadow state: a register write lands before any
			// command of the same edge, and a new command is queued behind older ones.
			if (cfg_valid && cfg_ready)
				page_limit = cfg_data;
			if (s_tvalid && s_tready) begin
				apply_page_command(s_tuser, s_tdata, want);
				results_due.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				got.status = m_tuser;
				got.granted = m_tdata[IDX_W-1:0];
				got.free_pages = m_tdata[IDX_W +: PAGE_W];
				if (results_due.size() == 0) begin
					flag_mismatch("result with no command outstanding", '0, got);
				end else begin
					want = results_due.pop_front();
					if (got.status !== want.status || got.granted !== want.granted ||
							got.free_pages !== want.free_pages)
						flag_mismatch("wrong result", want, got);
				end
			end
		end
		results_pending <= results_due.size();
	end

endmodule

// File: verif/tb_bitmap_page_allocator_top.sv
`timescale 1ns / 1ps

module tb_bitmap_page_allocator_top;
	import bpa_pkg::*;

	// The command field has one encoding with no operation behind it.
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	// The slowest command reduces the cursor with the divider and then reads up to 1025 bitmap
	// words; the limit is several times the slowest correct run.
	localparam int CYCLE_LIMIT = 3_000_000;
	// Quiet time after the last result, about one full allocate scan.
	localparam int SETTLE_CYCLES = 1100;
	// Length of the single long receiver hold-off.
	localparam int HOLD_CYCLES = 400;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IDX_W-1:0]      s_tdata = '0;   // [15:0] page_index
	logic [CMD_W-1:0]      s_tuser = '0;   // [1:0] cmd
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;        // [15:0] granted_page, [32:16] free_pages, rest 0
	logic [STATUS_W-1:0]   m_tuser;        // [1:0] status
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [PAGE_W-1:0]     cfg_data = '0;

	int mismatches;
	int results_pending;
	int cycle_count = 0;

	// Percent of cycles in which each side stays idle; changed between phases.
	int send_gap_pct = 19;
	int accept_gap_pct = 53;

	// The stimulus raises hold_request once; the receiver process then counts out the stall.
	logic hold_request = 1'b0;
	logic hold_done = 1'b0;
	int   hold_left = 0;

	bitmap_page_allocator_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	bpa_result_checker allocator_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.mismatches      (mismatches),
		.results_pending (results_pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// A run that hangs ends here instead of forever.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Result side: random back-pressure, plus one long hold-off so that the block has a
	// finished word it cannot hand over while new commands keep arriving.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_request && !hold_done) begin
			m_tready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= accept_gap_pct);
		end
	end

	// Offers one command word, with random idle cycles in front of it, and returns after the
	// first edge at which s_tready reads high. tvalid stays high so a following word can go out back to back.
	task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx);
		while ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= idx;
		s_tuser <= cmd;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Ends the command stream and waits until every issued command has its result. The
	// first edge is skipped because the checker's pending count is registered and lags behind.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (results_pending != 0)
			@(posedge clk);
	endtask

	// Every command returns a result, so the block is idle once the results have drained.
	task automatic write_page_limit(input logic [PAGE_W-1:0] value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Random commands against one page count. Most indexes fall inside the managed range
	// so that free and reserve hit both used and free pages; a few land out of range.
	task automatic random_phase(input logic [PAGE_W-1:0] limit, input int items,
			input int hold_at);
		int               span;
		int               roll;
		logic [CMD_W-1:0] cmd;
		logic [IDX_W-1:0] idx;
		write_page_limit(limit);
		span = (limit > MAX_PAGES_DEF) ? MAX_PAGES_DEF : int'(limit);
		for (int k = 0; k < items; k++) begin
			if (k == hold_at)
				hold_request <= 1'b1;
			roll = $urandom_range(99);
			idx = IDX_W'((span > 0) ? $urandom_range(span - 1) : $urandom);
			if (roll < 40) begin
				cmd = CMD_ALLOC;
				idx = IDX_W'($urandom);
			end else if (roll < 68) begin
				cmd = CMD_FREE;
			end else if (roll < 90) begin
				cmd = CMD_RESERVE;
			end else if (roll < 97) begin
				cmd = roll[0] ? CMD_FREE : CMD_RESERVE;
				idx = IDX_W'((span < MAX_PAGES_DEF) ? $urandom_range(65535, span) : $urandom);
			end else begin
				cmd = CMD_UNUSED;
				idx = IDX_W'($urandom);
			end
			send_word(cmd, idx);
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset page count, where every page starts out used.
		send_word(CMD_ALLOC, 16'd0);        // nothing free yet
		send_word(CMD_RESERVE, 16'd0);      // page already used
		send_word(CMD_FREE, 16'hFFFF);      // highest page
		send_word(CMD_FREE, 16'd0);
		send_word(CMD_FREE, 16'd0);         // page already free
		send_word(CMD_FREE, 16'd5);
		send_word(CMD_ALLOC, 16'd0);        // page 0
		send_word(CMD_ALLOC, 16'd0);        // page 5
		send_word(CMD_ALLOC, 16'd0);        // top page; cursor moves to the page count
		send_word(CMD_ALLOC, 16'd0);        // full scan finds nothing
		send_word(CMD_FREE, 16'd100);
		send_word(CMD_RESERVE, 16'd100);
		send_word(CMD_RESERVE, 16'd100);    // page already used
		send_word(CMD_UNUSED, 16'hABCD);    // no operation

		// A page count of zero manages nothing at all.
		write_page_limit('0);
		send_word(CMD_ALLOC, 16'd0);
		send_word(CMD_FREE, 16'd0);
		send_word(CMD_RESERVE, 16'd0);

		// With 100 pages the cursor left behind lies beyond the count and must wrap.
		write_page_limit(17'd100);
		send_word(CMD_FREE, 16'd40);
		send_word(CMD_FREE, 16'd99);
		send_word(CMD_ALLOC, 16'd0);
		send_word(CMD_FREE, 16'd100);       // first index out of range
		send_word(CMD_RESERVE, 16'hFFFF);   // last index out of range
		send_word(CMD_ALLOC, 16'd0);
		send_word(CMD_ALLOC, 16'd0);        // wraps all the way round, nothing free
		send_word(CMD_FREE, 16'd99);

		// Sender idles a little, receiver a lot.
		random_phase(17'd1, 30, -1);
		random_phase(17'd64, 60, -1);
		random_phase(17'd200, 60, -1);
		random_phase(17'd65536, 20, -1);

		// The other way round; an oversized count is clamped to the bitmap size.
		drain_results();
		send_gap_pct = 53;
		accept_gap_pct = 19;
		random_phase(17'd65, 60, -1);
		random_phase(17'h1FFFF, 15, -1);
		random_phase(17'd37, 60, -1);
		random_phase(17'd128, 60, -1);

		// Neither side idles; the long receiver stall falls into this stretch.
		drain_results();
		send_gap_pct = 0;
		accept_gap_pct = 0;
		random_phase(17'd65535, 15, -1);
		random_phase(17'd300, 80, 20);
		random_phase(17'd2, 30, -1);
		random_phase(PAGE_W'($urandom_range(500, 1)), 60, -1);

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && results_pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
